FILE: rtl/core/pbfe_pkg.sv
// Shared types and constants for the postfix byte formula evaluator.
// Used by every module of the block but pbfe_div; depends on nothing.
`timescale 1ns / 1ps

package pbfe_pkg;

	localparam logic       REQ_LOAD   = 1'b0;
	localparam logic       REQ_EVAL   = 1'b1;

	localparam logic [2:0] KIND_OP    = 3'd4;
	localparam logic [2:0] KIND_CONST = 3'd5;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_SUB     = 2'd1;
	localparam logic [1:0] OP_MUL     = 2'd2;
	localparam logic [1:0] OP_DIV     = 2'd3;

	localparam logic [1:0] EVAL_OK    = 2'd0;
	localparam logic [1:0] EVAL_UNDER = 2'd1;
	localparam logic [1:0] EVAL_DIVZ  = 2'd2;
	localparam logic [1:0] EVAL_DEPTH = 2'd3;

	typedef struct packed {
		logic               req_type;
		logic [3:0]         token_index;
		logic [2:0]         token_kind;
		logic [1:0]         token_op;
		logic signed [31:0] token_value;
		logic [7:0]         byte_a;
		logic [7:0]         byte_b;
		logic [7:0]         byte_c;
		logic [7:0]         byte_d;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [1:0]         eval_status;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  op;
		logic [31:0] value;
	} token_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_DIV,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       push;
		logic       alu;
		logic       div_start;
		logic       div_commit;
		logic       advance;
		logic       err_set;
		logic [1:0] err_code;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] op;
		logic       pc_end;
		logic       depth_lt2;
		logic       rhs_zero;
		logic       div_done;
	} dp_status_t;

endpackage

FILE: rtl/core/pbfe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module pbfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted  = {rem_q, quo_q[31]};
	assign diff     = shifted - {1'b0, den_q};
	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

FILE: rtl/core/pbfe_dp.sv
// Datapath: program store, value stack with top in a register, ALU, divider
// and response register. Depends on pbfe_pkg and pbfe_div.
`timescale 1ns / 1ps

module pbfe_dp import pbfe_pkg::*; #(
	parameter int MAX_TOKENS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  req_item_t  req_data,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	output dp_status_t status,
	output rsp_item_t  rsp_data
);

	localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
	localparam int CNT_W = $clog2(MAX_TOKENS + 1);

	token_t            prog_mem [MAX_TOKENS];
	token_t            prog_rd_q;
	logic [31:0]       stk_mem [MAX_TOKENS];
	logic [31:0]       stk_rd_q;
	logic [4:0]        plen_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  pc_q;
	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  depth_m1;
	logic [CNT_W-1:0]  depth_m2;
	logic [CNT_W-1:0]  len_sat;
	logic [7:0]        byte_q [4];
	logic [31:0]       tos_q;
	logic [1:0]        err_q;
	rsp_item_t         rsp_q;
	logic              idx_ok;
	logic              push_ok;
	logic              push_wr;
	logic [31:0]       push_val;
	logic [31:0]       alu_res;
	logic [31:0]       div_quo;
	logic              div_done;

	assign idx_ok   = {28'd0, req_data.token_index} < 32'(MAX_TOKENS);
	assign depth_m1 = depth_q - CNT_W'(1);
	assign depth_m2 = depth_q - CNT_W'(2);
	assign push_ok  = cmd.push && (32'(depth_q) < 32'(MAX_TOKENS));
	assign push_wr  = push_ok && (depth_q != '0);
	assign len_sat  = ({27'd0, plen_q} > 32'(MAX_TOKENS)) ? CNT_W'(MAX_TOKENS) : CNT_W'(plen_q);

	always_comb begin
		if (prog_rd_q.kind < KIND_OP) begin
			push_val = {24'd0, byte_q[prog_rd_q.kind[1:0]]};
		end else begin
			push_val = prog_rd_q.value;
		end
	end

	always_comb begin
		unique case (prog_rd_q.op)
			OP_ADD:  alu_res = stk_rd_q + tos_q;
			OP_SUB:  alu_res = stk_rd_q - tos_q;
			OP_MUL:  alu_res = stk_rd_q * tos_q;
			default: alu_res = stk_rd_q;
		endcase
	end

	pbfe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (stk_rd_q),
		.divisor  (tos_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok) begin
			prog_mem[IDX_W'(req_data.token_index)] <= '{
				kind:  req_data.token_kind,
				op:    req_data.token_op,
				value: req_data.token_value
			};
		end
		prog_rd_q <= prog_mem[pc_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push_wr) begin
			stk_mem[depth_m1[IDX_W-1:0]] <= tos_q;
		end
		stk_rd_q <= stk_mem[depth_m2[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			len_q   <= '0;
			pc_q    <= '0;
			depth_q <= '0;
			err_q   <= EVAL_OK;
		end else begin
			if (cfg_we) begin
				plen_q <= cfg_wdata;
			end
			if (cmd.start) begin
				len_q   <= len_sat;
				pc_q    <= '0;
				depth_q <= '0;
				err_q   <= EVAL_OK;
			end else begin
				if (cmd.advance) begin
					pc_q <= pc_q + CNT_W'(1);
				end
				if (push_ok) begin
					depth_q <= depth_q + CNT_W'(1);
				end else if (cmd.alu || cmd.div_commit) begin
					depth_q <= depth_m1;
				end
				if (cmd.err_set) begin
					err_q <= cmd.err_code;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			byte_q[0] <= req_data.byte_a;
			byte_q[1] <= req_data.byte_b;
			byte_q[2] <= req_data.byte_c;
			byte_q[3] <= req_data.byte_d;
		end
		if (push_ok) begin
			tos_q <= push_val;
		end else if (cmd.alu) begin
			tos_q <= alu_res;
		end else if (cmd.div_commit) begin
			tos_q <= div_quo;
		end
		if (cmd.finish) begin
			if (err_q != EVAL_OK) begin
				rsp_q.result_value <= '0;
				rsp_q.eval_status  <= err_q;
			end else if (32'(depth_q) != 32'd1) begin
				rsp_q.result_value <= '0;
				rsp_q.eval_status  <= EVAL_DEPTH;
			end else begin
				rsp_q.result_value <= tos_q;
				rsp_q.eval_status  <= EVAL_OK;
			end
		end
	end

	assign rsp_data         = rsp_q;
	assign status.kind      = prog_rd_q.kind;
	assign status.op        = prog_rd_q.op;
	assign status.pc_end    = (pc_q == len_q);
	assign status.depth_lt2 = 32'(depth_q) < 32'd2;
	assign status.rhs_zero  = (tos_q == 32'd0);
	assign status.div_done  = div_done;

endmodule

FILE: rtl/core/pbfe_ctrl.sv
// Controller: sequences loads and token-by-token evaluation, owns the handshakes.
// Depends on pbfe_pkg.
`timescale 1ns / 1ps

module pbfe_ctrl import pbfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_type,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && (req_type == REQ_EVAL)) begin
					state_nxt = S_FETCH;
				end
			end
			S_FETCH: begin
				state_nxt = status.pc_end ? S_FINISH : S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_FETCH;
				if (status.kind == KIND_OP) begin
					priority if (status.depth_lt2) begin
						state_nxt = S_FINISH;
					end else if (status.op == OP_DIV) begin
						state_nxt = status.rhs_zero ? S_FINISH : S_DIV;
					end
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_nxt = S_FETCH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid && (req_type == REQ_LOAD);
				cmd.start = req_valid && (req_type == REQ_EVAL);
			end
			S_EXEC: begin
				priority if (status.kind < KIND_OP || status.kind == KIND_CONST) begin
					cmd.push    = 1'b1;
					cmd.advance = 1'b1;
				end else if (status.kind == KIND_OP) begin
					priority if (status.depth_lt2) begin
						cmd.err_set  = 1'b1;
						cmd.err_code = EVAL_UNDER;
					end else if (status.op == OP_DIV) begin
						if (status.rhs_zero) begin
							cmd.err_set  = 1'b1;
							cmd.err_code = EVAL_DIVZ;
						end else begin
							cmd.div_start = 1'b1;
						end
					end else begin
						cmd.alu     = 1'b1;
						cmd.advance = 1'b1;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_commit = status.div_done;
				cmd.advance    = status.div_done;
			end
			S_FINISH: begin
				cmd.finish = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/postfix_byte_formula_evaluator.sv
// Top level of the postfix byte formula evaluator: controller plus datapath.
// Depends on pbfe_pkg, pbfe_ctrl, pbfe_dp and pbfe_div.
`timescale 1ns / 1ps

// A load transaction writes one program token and returns nothing. An
// evaluate transaction runs the first cfg_wdata-programmed number of tokens,
// capped at MAX_TOKENS and stopping at the first error, over a value stack
// with 32-bit wrapping arithmetic and returns one response. Each token passes
// through a fetch state, for the registered program memory read, and an
// execute state; a division adds the radix-2 divider, one quotient bit per
// cycle, and then a commit of the quotient. A finished response waits in its
// own register, so the next transaction is accepted while it is pending; an
// evaluation that ends while that register is still held waits in its last
// state until the receiver takes the earlier response.

module postfix_byte_formula_evaluator import pbfe_pkg::*; #(
	parameter int MAX_TOKENS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_item_t  req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_item_t  rsp_data,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	pbfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pbfe_dp #(
		.MAX_TOKENS (MAX_TOKENS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for postfix_byte_formula_evaluator: random idling on both channels,
// a built-in predictor and an in-order check of every response. Depends on pbfe_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import pbfe_pkg::*;

	localparam int        TOKEN_SLOTS = 16;
	localparam int        SETTLE      = 40;
	localparam int        HOLD_CYCLES = 400;
	localparam int        CYCLE_LIMIT = 1000000;
	localparam int        RANDOM_ITEMS = 800;

	localparam logic [2:0] KIND_A     = 3'd0;
	localparam logic [2:0] KIND_B     = 3'd1;
	localparam logic [2:0] KIND_C     = 3'd2;
	localparam logic [2:0] KIND_D     = 3'd3;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_item_t  req_data = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_item_t  rsp_data;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;

	req_item_t  outgoing_requests [$];
	rsp_item_t  awaited_results [$];
	token_t     prog_tokens [TOKEN_SLOTS];
	logic [4:0] prog_len = '0;

	int queued_count = 0;
	int req_taken = 0;
	int req_seen = 0;
	int req_gap = 0;
	int rsp_taken = 0;
	int rsp_seen = 0;
	int rsp_gap = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycles = 0;
	bit no_gaps = 1'b0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;

	postfix_byte_formula_evaluator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic rsp_item_t evaluate_formula(input logic [7:0] ba, input logic [7:0] bb,
			input logic [7:0] bc, input logic [7:0] bd);
		logic [31:0] stack_vals [TOKEN_SLOTS];
		logic [7:0]  frame [4];
		logic [31:0] lhs, rhs, res, ua, ub, q;
		logic [1:0]  status;
		int          depth, len, i;
		rsp_item_t   out;
		frame[0] = ba;
		frame[1] = bb;
		frame[2] = bc;
		frame[3] = bd;
		len = (prog_len > TOKEN_SLOTS) ? TOKEN_SLOTS : int'(prog_len);
		depth = 0;
		status = EVAL_OK;
		for (i = 0; i < len && status == EVAL_OK; i++) begin
			if (prog_tokens[i].kind < KIND_OP) begin
				if (depth < TOKEN_SLOTS) begin
					stack_vals[depth] = {24'd0, frame[prog_tokens[i].kind[1:0]]};
					depth++;
				end
			end else if (prog_tokens[i].kind == KIND_CONST) begin
				if (depth < TOKEN_SLOTS) begin
					stack_vals[depth] = prog_tokens[i].value;
					depth++;
				end
			end else if (prog_tokens[i].kind == KIND_OP) begin
				if (depth < 2) begin
					status = EVAL_UNDER;
				end else begin
					rhs = stack_vals[depth - 1];
					lhs = stack_vals[depth - 2];
					depth -= 2;
					res = '0;
					case (prog_tokens[i].op)
						OP_ADD: res = lhs + rhs;
						OP_SUB: res = lhs - rhs;
						OP_MUL: res = lhs * rhs;
						default: begin
							if (rhs == '0) begin
								status = EVAL_DIVZ;
							end else begin
								ua = lhs[31] ? (32'd0 - lhs) : lhs;
								ub = rhs[31] ? (32'd0 - rhs) : rhs;
								q = ua / ub;
								res = (lhs[31] ^ rhs[31]) ? (32'd0 - q) : q;
							end
						end
					endcase
					if (status == EVAL_OK) begin
						stack_vals[depth] = res;
						depth++;
					end
				end
			end
		end
		out.result_value = '0;
		if (status == EVAL_OK) begin
			if (depth != 1)
				status = EVAL_DEPTH;
			else
				out.result_value = stack_vals[0];
		end
		out.eval_status = status;
		return out;
	endfunction

	function automatic logic [31:0] rand_const();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0, 1: return 8'h00;
			2: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic queue_load(input logic [3:0] idx, input logic [2:0] kind, input logic [1:0] op,
			input logic [31:0] value);
		req_item_t item;
		item = '0;
		item.req_type    = REQ_LOAD;
		item.token_index = idx;
		item.token_kind  = kind;
		item.token_op    = op;
		item.token_value = value;
		item.byte_a      = 8'($urandom);
		item.byte_b      = 8'($urandom);
		item.byte_c      = 8'($urandom);
		item.byte_d      = 8'($urandom);
		outgoing_requests.push_back(item);
		queued_count++;
	endtask

	task automatic queue_eval(input logic [7:0] ba, input logic [7:0] bb, input logic [7:0] bc,
			input logic [7:0] bd);
		req_item_t item;
		item.req_type    = REQ_EVAL;
		item.token_index = 4'($urandom);
		item.token_kind  = 3'($urandom);
		item.token_op    = 2'($urandom);
		item.token_value = $urandom;
		item.byte_a      = ba;
		item.byte_b      = bb;
		item.byte_c      = bc;
		item.byte_d      = bd;
		outgoing_requests.push_back(item);
		queued_count++;
	endtask

	task automatic wait_drained();
		while (!(req_taken == queued_count && awaited_results.size() == 0))
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_length(input logic [4:0] len);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		prog_len   = len;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Build a well-formed program of n tokens that, for n above zero, leaves exactly one value.
	task automatic load_formula(input int n);
		int   i, r, d, pick;
		bit   can_push, can_op, can_skip;
		d = 0;
		for (i = 0; i < n; i++) begin
			r = n - i;
			can_push = (d + 1 <= r);
			can_op   = (d >= 2);
			can_skip = (d <= r) && !(d == 0 && r == 1);
			pick = $urandom_range(0, 9);
			if (can_skip && (pick == 0 || (!can_push && !can_op))) begin
				queue_load(4'(i), $urandom_range(0, 1) ? KIND_RSVD7 : KIND_RSVD6,
					2'($urandom), $urandom);
			end else if (can_op && (!can_push || pick >= 5)) begin
				queue_load(4'(i), KIND_OP, 2'($urandom), $urandom);
				d--;
			end else begin
				if ($urandom_range(0, 4) == 0)
					queue_load(4'(i), KIND_CONST, 2'($urandom), rand_const());
				else
					queue_load(4'(i), 3'($urandom_range(0, 3)), 2'($urandom), $urandom);
				d++;
			end
		end
	endtask

	always @(negedge clk) begin : request_driver
		logic      nxt_valid;
		req_item_t nxt_item;
		nxt_valid = req_valid;
		nxt_item  = req_data;
		if (arst_n) begin
			if (req_valid && req_taken != req_seen) begin
				req_seen  = req_taken;
				nxt_valid = 1'b0;
				req_gap   = no_gaps ? 0 : $urandom_range(0, 16);
			end
			if (!nxt_valid) begin
				if (req_gap != 0) begin
					req_gap--;
				end else if (outgoing_requests.size() != 0) begin
					nxt_item  = outgoing_requests.pop_front();
					nxt_valid = 1'b1;
				end
			end
		end
		req_valid <= nxt_valid;
		req_data  <= nxt_item;
	end

	always @(negedge clk) begin : response_sink
		if (rsp_taken != rsp_seen) begin
			rsp_seen = rsp_taken;
			rsp_gap  = no_gaps ? 0 : $urandom_range(0, 16);
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (rsp_gap != 0) begin
			rsp_gap--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_taken++;
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected response value %0d status %0d", $realtime,
							rsp_data.result_value, rsp_data.eval_status);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp_data.result_value !== want.result_value ||
							rsp_data.eval_status !== want.eval_status) begin
						if (mismatches < 10)
							$display("%0t: wrong response: value %0d status %0d, wanted value %0d status %0d",
								$realtime, rsp_data.result_value, rsp_data.eval_status,
								want.result_value, want.eval_status);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) begin
				req_taken++;
				if (req_data.req_type == REQ_LOAD) begin
					prog_tokens[req_data.token_index].kind  = req_data.token_kind;
					prog_tokens[req_data.token_index].op    = req_data.token_op;
					prog_tokens[req_data.token_index].value = req_data.token_value;
				end else begin
					awaited_results.push_back(evaluate_formula(req_data.byte_a,
						req_data.byte_b, req_data.byte_c, req_data.byte_d));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, len, eff, nev, k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty program
		set_length(5'd0);
		queue_eval(8'hFF, 8'hFF, 8'hFF, 8'hFF);

		// most negative over minus one, then a zero divisor
		set_length(5'd3);
		queue_load(4'd0, KIND_CONST, OP_ADD, 32'h8000_0000);
		queue_load(4'd1, KIND_CONST, OP_ADD, 32'hFFFF_FFFF);
		queue_load(4'd2, KIND_OP, OP_DIV, 32'd0);
		queue_eval(8'h00, 8'h00, 8'h00, 8'h00);
		queue_load(4'd1, KIND_CONST, OP_SUB, 32'd0);
		queue_eval(8'hFF, 8'h00, 8'hFF, 8'h00);

		// operator on an empty stack
		set_length(5'd1);
		queue_load(4'd0, KIND_OP, OP_ADD, 32'd0);
		queue_eval(8'hFF, 8'hFF, 8'hFF, 8'hFF);

		// full program with every byte, every operator and both reserved kinds
		set_length(5'd31);
		queue_load(4'd0, KIND_A, OP_ADD, $urandom);
		queue_load(4'd1, KIND_B, OP_SUB, $urandom);
		queue_load(4'd2, KIND_OP, OP_ADD, $urandom);
		queue_load(4'd3, KIND_C, OP_MUL, $urandom);
		queue_load(4'd4, KIND_OP, OP_SUB, $urandom);
		queue_load(4'd5, KIND_D, OP_DIV, $urandom);
		queue_load(4'd6, KIND_OP, OP_MUL, $urandom);
		queue_load(4'd7, KIND_RSVD6, OP_DIV, $urandom);
		queue_load(4'd8, KIND_CONST, OP_ADD, 32'd7);
		queue_load(4'd9, KIND_OP, OP_DIV, $urandom);
		queue_load(4'd10, KIND_RSVD7, OP_SUB, $urandom);
		queue_load(4'd11, KIND_CONST, OP_MUL, 32'h7FFF_FFFF);
		queue_load(4'd12, KIND_OP, OP_ADD, $urandom);
		queue_load(4'd13, KIND_B, OP_ADD, $urandom);
		queue_load(4'd14, KIND_OP, OP_MUL, $urandom);
		queue_load(4'd15, KIND_RSVD6, OP_ADD, $urandom);
		queue_eval(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_eval(8'h00, 8'hFF, 8'h00, 8'h01);
		set_length(5'd16);
		queue_eval(rand_byte(), rand_byte(), rand_byte(), rand_byte());

		phase = 0;
		while (queued_count < RANDOM_ITEMS + 30) begin
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = TOKEN_SLOTS;
				2: len = $urandom_range(17, 31);
				default: len = $urandom_range(1, 16);
			endcase
			set_length(5'(len));
			eff = (len > TOKEN_SLOTS) ? TOKEN_SLOTS : len;
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) != 0)
				load_formula(eff);
			nev = $urandom_range(2, 8);
			// stall the response side while the sender keeps going
			if (phase == 20) begin
				hold_armed = 1'b1;
				nev = 16;
			end
			for (k = 0; k < nev; k++) begin
				if ($urandom_range(0, 5) == 0)
					queue_load(4'($urandom), 3'($urandom), 2'($urandom), rand_const());
				queue_eval(rand_byte(), rand_byte(), rand_byte(), rand_byte());
			end
			phase++;
		end

		wait_drained();
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
